### rtl/core/assert_macros.svh
// Assertion macros used by the checker file efva_checker.sv of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define EFVA_ASSERT_RST(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define EFVA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/efva_pkg.sv
// Shared types, constants and functions of the edge force and virial accumulator.
package efva_pkg;

  localparam int unsigned NODE_COUNT_MAX_DEF = 65536;
  localparam int unsigned VALUE_WIDTH_DEF    = 32;
  localparam int unsigned FRAC_BITS_DEF      = 16;

  localparam int unsigned IN_W    = 32;
  localparam int unsigned ACC_W   = 48;
  localparam int unsigned SUM_W   = 66;
  localparam int unsigned NODE_W  = 16;
  localparam int unsigned CNT_W   = 21;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

  typedef logic signed [IN_W-1:0]  val_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [2:0] {
    ROW_FORCE = 3'd0,
    ROW_VIR_X = 3'd1,
    ROW_VIR_Y = 3'd2,
    ROW_VIR_Z = 3'd3,
    ROW_MAG   = 3'd4
  } row_kind_t;

  typedef struct packed {
    logic add_force;
    logic sub_force;
    logic do_virial;
    logic do_spin;
    logic last;
  } cls_t;

  typedef struct packed {
    cls_t                 cls;
    logic [2:0][IN_W-1:0] grad;
    logic [2:0][IN_W-1:0] vec;
    logic [2:0][IN_W-1:0] spin;
  } item_t;

  typedef struct packed {
    logic [NODE_W-1:0]     node;
    logic                  spin;
    logic [2:0][ACC_W-1:0] frc;
    logic [8:0][ACC_W-1:0] vir;
    logic [2:0][ACC_W-1:0] mag;
  } bank_t;

  function automatic acc_t sat48(input logic signed [SUM_W-1:0] x);
    acc_t r;
    if (x > SAT_HI) begin
      r = SAT_HI[ACC_W-1:0];
    end else if (x < SAT_LO) begin
      r = SAT_LO[ACC_W-1:0];
    end else begin
      r = x[ACC_W-1:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/efva_front.sv
// Front end: sign-extends the item fields and classifies each edge for the back end.
module efva_front #(
  parameter int unsigned VALUE_WIDTH = efva_pkg::VALUE_WIDTH_DEF
) (
  input  logic                     spin_enable,
  input  logic                     role,
  input  logic                     edge_valid,
  input  logic                     node_last,
  input  logic [2:0][efva_pkg::IN_W-1:0] grad,
  input  logic [2:0][efva_pkg::IN_W-1:0] vec,
  input  logic [2:0][efva_pkg::IN_W-1:0] spin,
  output efva_pkg::item_t          item
);

  localparam int unsigned TW = (VALUE_WIDTH < efva_pkg::IN_W) ? VALUE_WIDTH : efva_pkg::IN_W;
  localparam int unsigned SH = efva_pkg::IN_W - TW;

  function automatic efva_pkg::val_t take(input logic [efva_pkg::IN_W-1:0] raw);
    efva_pkg::val_t t;
    t = raw << SH;
    return t >>> SH;
  endfunction

  always_comb begin
    item.cls.add_force = edge_valid & ~role;
    item.cls.sub_force = edge_valid & role;
    item.cls.do_virial = edge_valid & role;
    item.cls.do_spin   = edge_valid & role & spin_enable;
    item.cls.last      = node_last;
    for (int i = 0; i < 3; i++) begin
      item.grad[i] = take(grad[i]);
      item.vec[i]  = take(vec[i]);
      item.spin[i] = take(spin[i]);
    end
  end

endmodule

### rtl/core/efva_queue.sv
// Short first-in first-out queue of classified items between the front and back ends.
module efva_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  efva_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output efva_pkg::item_t pop_item
);

  efva_pkg::item_t                 slots [efva_pkg::QUEUE_DEPTH];
  logic [efva_pkg::QPTR_W-1:0]     wr_ptr;
  logic [efva_pkg::QPTR_W-1:0]     rd_ptr;
  logic [efva_pkg::QCNT_W-1:0]     count;

  assign full      = (count == efva_pkg::QCNT_W'(efva_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

### rtl/core/efva_back.sv
// Back end: registered outer-product multipliers and saturating 48-bit accumulators.
module efva_back #(
  parameter int unsigned NODE_COUNT_MAX = efva_pkg::NODE_COUNT_MAX_DEF,
  parameter int unsigned FRAC_BITS      = efva_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            spin_enable,
  input  logic            q_valid,
  input  efva_pkg::item_t q_item,
  output logic            q_pop,
  input  logic            bank_ready,
  output logic            bank_load,
  output efva_pkg::bank_t bank_data
);

  logic                        m_valid;
  efva_pkg::cls_t              m_cls;
  logic signed [63:0]          m_prod [9];
  efva_pkg::val_t              m_grad [3];
  efva_pkg::val_t              m_spin [3];

  efva_pkg::acc_t              frc [3];
  efva_pkg::acc_t              vir [9];
  efva_pkg::acc_t              mag [3];
  efva_pkg::acc_t              frc_next [3];
  efva_pkg::acc_t              vir_next [9];
  efva_pkg::acc_t              mag_next [3];
  logic [efva_pkg::NODE_W-1:0] node_counter;
  logic [efva_pkg::NODE_W-1:0] node_counter_next;
  logic [efva_pkg::CNT_W-1:0]  cnt_inc;
  logic                        advance;

  assign advance   = !(m_valid && m_cls.last && !bank_ready);
  assign q_pop     = q_valid && advance;
  assign bank_load = m_valid && m_cls.last && advance;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      m_cls <= q_item.cls;
      for (int i = 0; i < 3; i++) begin
        m_grad[i] <= $signed(q_item.grad[i]);
        m_spin[i] <= $signed(q_item.spin[i]);
        for (int j = 0; j < 3; j++) begin
          m_prod[i*3+j] <= 64'($signed(q_item.grad[i])) * 64'($signed(q_item.vec[j]));
        end
      end
    end
  end

  always_comb begin
    logic signed [efva_pkg::SUM_W-1:0] a;
    logic signed [efva_pkg::SUM_W-1:0] b;
    logic signed [63:0]                p;
    for (int i = 0; i < 3; i++) begin
      a = {{(efva_pkg::SUM_W-efva_pkg::ACC_W){frc[i][efva_pkg::ACC_W-1]}}, frc[i]};
      b = {{(efva_pkg::SUM_W-efva_pkg::IN_W){m_grad[i][efva_pkg::IN_W-1]}}, m_grad[i]};
      if (m_cls.add_force) begin
        frc_next[i] = efva_pkg::sat48(a + b);
      end else if (m_cls.sub_force) begin
        frc_next[i] = efva_pkg::sat48(a - b);
      end else begin
        frc_next[i] = frc[i];
      end
      a = {{(efva_pkg::SUM_W-efva_pkg::ACC_W){mag[i][efva_pkg::ACC_W-1]}}, mag[i]};
      b = {{(efva_pkg::SUM_W-efva_pkg::IN_W){m_spin[i][efva_pkg::IN_W-1]}}, m_spin[i]};
      mag_next[i] = m_cls.do_spin ? efva_pkg::sat48(a + b) : mag[i];
    end
    for (int k = 0; k < 9; k++) begin
      p = m_prod[k] >>> FRAC_BITS;
      a = {{(efva_pkg::SUM_W-efva_pkg::ACC_W){vir[k][efva_pkg::ACC_W-1]}}, vir[k]};
      b = {{(efva_pkg::SUM_W-64){p[63]}}, p};
      vir_next[k] = m_cls.do_virial ? efva_pkg::sat48(a - b) : vir[k];
    end
  end

  always_comb begin
    cnt_inc = {{(efva_pkg::CNT_W-efva_pkg::NODE_W){1'b0}}, node_counter} + 1'b1;
    if (cnt_inc >= efva_pkg::CNT_W'(NODE_COUNT_MAX)) begin
      node_counter_next = '0;
    end else begin
      node_counter_next = cnt_inc[efva_pkg::NODE_W-1:0];
    end
  end

  always_comb begin
    bank_data.node = node_counter;
    bank_data.spin = spin_enable;
    for (int i = 0; i < 3; i++) begin
      bank_data.frc[i] = frc_next[i];
      bank_data.mag[i] = mag_next[i];
    end
    for (int k = 0; k < 9; k++) begin
      bank_data.vir[k] = vir_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid      <= 1'b0;
      node_counter <= '0;
      for (int i = 0; i < 3; i++) begin
        frc[i] <= '0;
        mag[i] <= '0;
      end
      for (int k = 0; k < 9; k++) begin
        vir[k] <= '0;
      end
    end else if (advance) begin
      m_valid <= q_valid;
      if (m_valid && m_cls.last) begin
        node_counter <= node_counter_next;
        for (int i = 0; i < 3; i++) begin
          frc[i] <= '0;
          mag[i] <= '0;
        end
        for (int k = 0; k < 9; k++) begin
          vir[k] <= '0;
        end
      end else if (m_valid) begin
        for (int i = 0; i < 3; i++) begin
          frc[i] <= frc_next[i];
          mag[i] <= mag_next[i];
        end
        for (int k = 0; k < 9; k++) begin
          vir[k] <= vir_next[k];
        end
      end
    end
  end

endmodule

### rtl/core/efva_emit.sv
// Result bank that holds one finished node and sends its rows one per transaction.
module efva_emit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         bank_load,
  input  efva_pkg::bank_t              bank_data,
  output logic                         bank_ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [efva_pkg::NODE_W-1:0]  node_index,
  output logic [2:0]                   row_kind,
  output logic signed [efva_pkg::ACC_W-1:0] val_x,
  output logic signed [efva_pkg::ACC_W-1:0] val_y,
  output logic signed [efva_pkg::ACC_W-1:0] val_z,
  output logic                         row_last
);

  efva_pkg::bank_t     bank;
  logic                busy;
  efva_pkg::row_kind_t row;
  efva_pkg::row_kind_t row_next;
  logic                take;

  assign take       = busy && !out_stall;
  assign row_last   = bank.spin ? (row == efva_pkg::ROW_MAG) : (row == efva_pkg::ROW_VIR_Z);
  assign bank_ready = !busy || (take && row_last);
  assign out_valid  = busy;
  assign node_index = bank.node;
  assign row_kind   = row;

  always_comb begin
    unique case (row)
      efva_pkg::ROW_FORCE: row_next = efva_pkg::ROW_VIR_X;
      efva_pkg::ROW_VIR_X: row_next = efva_pkg::ROW_VIR_Y;
      efva_pkg::ROW_VIR_Y: row_next = efva_pkg::ROW_VIR_Z;
      efva_pkg::ROW_VIR_Z: row_next = efva_pkg::ROW_MAG;
      default:             row_next = efva_pkg::ROW_FORCE;
    endcase
  end

  always_comb begin
    unique case (row)
      efva_pkg::ROW_FORCE: begin
        val_x = bank.frc[0];
        val_y = bank.frc[1];
        val_z = bank.frc[2];
      end
      efva_pkg::ROW_VIR_X: begin
        val_x = bank.vir[0];
        val_y = bank.vir[1];
        val_z = bank.vir[2];
      end
      efva_pkg::ROW_VIR_Y: begin
        val_x = bank.vir[3];
        val_y = bank.vir[4];
        val_z = bank.vir[5];
      end
      efva_pkg::ROW_VIR_Z: begin
        val_x = bank.vir[6];
        val_y = bank.vir[7];
        val_z = bank.vir[8];
      end
      default: begin
        val_x = bank.mag[0];
        val_y = bank.mag[1];
        val_z = bank.mag[2];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= efva_pkg::ROW_FORCE;
    end else if (bank_load) begin
      busy <= 1'b1;
      row  <= efva_pkg::ROW_FORCE;
    end else if (take) begin
      if (row_last) begin
        busy <= 1'b0;
      end else begin
        row <= row_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (bank_load) begin
      bank <= bank_data;
    end
  end

endmodule

### rtl/core/edge_force_virial_accumulator.sv
// Throughput: one edge item per cycle while in_stall is low, through nine registered
// 32x32 multipliers and one saturating accumulate per cycle; a node sends four rows, or
// five with spin, one per cycle while out_stall is low, and a node that closes while the
// previous rows are still out holds the back end meanwhile.
// Reset: synchronous rst clears all sums, the node counter, spin_enable and the queue.
// Top level of the edge force and virial accumulator.
module edge_force_virial_accumulator #(
  parameter int unsigned NODE_COUNT_MAX = efva_pkg::NODE_COUNT_MAX_DEF,
  parameter int unsigned VALUE_WIDTH    = efva_pkg::VALUE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS      = efva_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic                              cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              role,
  input  logic                              edge_valid,
  input  logic signed [31:0]                grad_x,
  input  logic signed [31:0]                grad_y,
  input  logic signed [31:0]                grad_z,
  input  logic signed [31:0]                vec_x,
  input  logic signed [31:0]                vec_y,
  input  logic signed [31:0]                vec_z,
  input  logic signed [31:0]                spin_x,
  input  logic signed [31:0]                spin_y,
  input  logic signed [31:0]                spin_z,
  input  logic                              node_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [15:0]                       node_index,
  output logic [2:0]                        row_kind,
  output logic signed [47:0]                val_x,
  output logic signed [47:0]                val_y,
  output logic signed [47:0]                val_z,
  output logic                              row_last
);

  logic            spin_enable;
  efva_pkg::item_t f_item;
  efva_pkg::item_t q_item;
  logic            q_full;
  logic            q_valid;
  logic            q_pop;
  logic            push;
  logic            bank_ready;
  logic            bank_load;
  efva_pkg::bank_t bank_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      spin_enable <= 1'b0;
    end else if (cfg_write) begin
      spin_enable <= cfg_data;
    end
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  efva_front #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_front (
    .spin_enable(spin_enable),
    .role(role),
    .edge_valid(edge_valid),
    .node_last(node_last),
    .grad({grad_z, grad_y, grad_x}),
    .vec({vec_z, vec_y, vec_x}),
    .spin({spin_z, spin_y, spin_x}),
    .item(f_item)
  );

  efva_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_item(f_item),
    .full(q_full),
    .pop(q_pop),
    .not_empty(q_valid),
    .pop_item(q_item)
  );

  efva_back #(
    .NODE_COUNT_MAX(NODE_COUNT_MAX),
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .spin_enable(spin_enable),
    .q_valid(q_valid),
    .q_item(q_item),
    .q_pop(q_pop),
    .bank_ready(bank_ready),
    .bank_load(bank_load),
    .bank_data(bank_data)
  );

  efva_emit u_emit (
    .clk(clk),
    .rst(rst),
    .bank_load(bank_load),
    .bank_data(bank_data),
    .bank_ready(bank_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .node_index(node_index),
    .row_kind(row_kind),
    .val_x(val_x),
    .val_y(val_y),
    .val_z(val_z),
    .row_last(row_last)
  );

endmodule

### rtl/core/efva_checker.sv
// Port-level checker of the accumulator and its bind to the top level.
`include "assert_macros.svh"

module efva_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] node_index,
  input logic [2:0]  row_kind,
  input logic        row_last
);

  `EFVA_ASSERT_RST(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid, "stalled transaction dropped")
  `EFVA_ASSERT_RST(a_row_seq, clk, rst, out_valid && !out_stall && !row_last |=> out_valid && node_index == $past(node_index) && row_kind == $past(row_kind) + 3'd1, "rows of a node out of sequence")
  `EFVA_ASSERT_RST(a_last_kind, clk, rst, out_valid && row_last |-> row_kind == efva_pkg::ROW_VIR_Z || row_kind == efva_pkg::ROW_MAG, "last row of wrong kind")
  `EFVA_ASSERT_ALWAYS(a_reset_idle, clk, $past(rst) |-> !out_valid, "output valid right after reset")

endmodule

bind edge_force_virial_accumulator efva_checker u_efva_checker (.*);

### dv/efva_row_checker.sv
// Checker for the edge force and virial accumulator: predicts every output row and compares it.
module efva_row_checker
  import efva_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        role,
  input  logic        edge_valid,
  input  val_t        grad_x,
  input  val_t        grad_y,
  input  val_t        grad_z,
  input  val_t        vec_x,
  input  val_t        vec_y,
  input  val_t        vec_z,
  input  val_t        spin_x,
  input  val_t        spin_y,
  input  val_t        spin_z,
  input  logic        node_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] node_index,
  input  logic [2:0]  row_kind,
  input  acc_t        val_x,
  input  acc_t        val_y,
  input  acc_t        val_z,
  input  logic        row_last,
  output int          rows_waiting,
  output int          mismatch_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    row_kind_t         kind;
    acc_t              x;
    acc_t              y;
    acc_t              z;
    logic              last;
  } node_row_t;

  localparam longint SUM_HI = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam longint SUM_LO = -(64'sd1 <<< (ACC_W - 1));

  node_row_t         row_q[$];
  longint            force_acc[3];
  longint            virial_acc[9];
  longint            spin_acc[3];
  logic [NODE_W-1:0] node_num;
  logic              spin_on;
  int                mismatches = 0;

  function automatic longint clamp_acc(input longint v);
    if (v > SUM_HI) return SUM_HI;
    if (v < SUM_LO) return SUM_LO;
    return v;
  endfunction

  task automatic accumulate_edge(input logic outgoing, input logic counted,
                                 input logic [2:0][IN_W-1:0] g,
                                 input logic [2:0][IN_W-1:0] v,
                                 input logic [2:0][IN_W-1:0] s,
                                 input logic closes);
    longint gi;
    longint prod;
    if (counted) begin
      for (int i = 0; i < 3; i++) begin
        gi = longint'($signed(g[i]));
        force_acc[i] = clamp_acc(outgoing ? force_acc[i] - gi : force_acc[i] + gi);
        if (outgoing) begin
          for (int j = 0; j < 3; j++) begin
            prod = (gi * longint'($signed(v[j]))) >>> FRAC_BITS_DEF;
            virial_acc[3*i+j] = clamp_acc(virial_acc[3*i+j] - prod);
          end
          if (spin_on) begin
            spin_acc[i] = clamp_acc(spin_acc[i] + longint'($signed(s[i])));
          end
        end
      end
    end
    if (closes) begin
      row_q.push_back(node_row_t'{node_num, ROW_FORCE, acc_t'(force_acc[0]),
                                  acc_t'(force_acc[1]), acc_t'(force_acc[2]), 1'b0});
      for (int i = 0; i < 3; i++) begin
        row_q.push_back(node_row_t'{node_num, row_kind_t'(ROW_VIR_X + i),
                                    acc_t'(virial_acc[3*i]), acc_t'(virial_acc[3*i+1]),
                                    acc_t'(virial_acc[3*i+2]), (i == 2) && !spin_on});
      end
      if (spin_on) begin
        row_q.push_back(node_row_t'{node_num, ROW_MAG, acc_t'(spin_acc[0]),
                                    acc_t'(spin_acc[1]), acc_t'(spin_acc[2]), 1'b1});
      end
      force_acc  = '{default: 0};
      virial_acc = '{default: 0};
      spin_acc   = '{default: 0};
      if (int'(node_num) + 1 >= int'(NODE_COUNT_MAX_DEF)) begin
        node_num = '0;
      end else begin
        node_num = node_num + 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin
    node_row_t want;
    logic      ok;
    if (rst) begin
      row_q.delete();
      force_acc  = '{default: 0};
      virial_acc = '{default: 0};
      spin_acc   = '{default: 0};
      node_num   = '0;
      spin_on    = 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (row_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected row: node %0d kind %0d x %0d y %0d z %0d last %0b",
                     node_index, row_kind, val_x, val_y, val_z, row_last);
          end
        end else begin
          want = row_q.pop_front();
          ok = (node_index === want.node) && (row_kind === want.kind) &&
               (val_x === want.x) && (val_y === want.y) && (val_z === want.z) &&
               (row_last === want.last);
          if (!ok) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("row mismatch: expected node %0d kind %0d x %0d y %0d z %0d last %0b",
                       want.node, want.kind, want.x, want.y, want.z, want.last);
              $display("              got      node %0d kind %0d x %0d y %0d z %0d last %0b",
                       node_index, row_kind, val_x, val_y, val_z, row_last);
            end
          end
        end
      end
      if (cfg_write) begin
        spin_on = cfg_data;
      end
      if (in_valid && !in_stall) begin
        accumulate_edge(role, edge_valid, {grad_z, grad_y, grad_x}, {vec_z, vec_y, vec_x},
                        {spin_z, spin_y, spin_x}, node_last);
      end
    end
    rows_waiting   <= row_q.size();
    mismatch_count <= mismatches;
  end

endmodule

### dv/edge_force_virial_accumulator_tb.sv
// Testbench top for the edge force and virial accumulator: stimulus, receiver stalls and verdict.
module edge_force_virial_accumulator_tb;
  import efva_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   IDLE_LIMIT    = 4000;
  localparam int   SETTLE_CYCLES = 8;
  localparam int   RANDOM_PHASES = 6;
  localparam int   PHASE_ITEMS   = 75;
  localparam logic ROLE_IN       = 1'b0;
  localparam logic ROLE_OUT      = 1'b1;
  localparam logic SPIN_OFF      = 1'b0;
  localparam logic SPIN_ON       = 1'b1;
  localparam val_t VAL_MAX       = 32'sh7FFFFFFF;
  localparam val_t VAL_MIN       = 32'sh80000000;

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_WAVE} stall_mode_t;

  typedef struct packed {
    logic                 role;
    logic                 counted;
    logic [2:0][IN_W-1:0] grad;
    logic [2:0][IN_W-1:0] vec;
    logic [2:0][IN_W-1:0] spin;
    logic                 last;
  } edge_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic        cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic        role;
  logic        edge_valid;
  val_t        grad_x, grad_y, grad_z;
  val_t        vec_x, vec_y, vec_z;
  val_t        spin_x, spin_y, spin_z;
  logic        node_last;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] node_index;
  logic [2:0]  row_kind;
  acc_t        val_x, val_y, val_z;
  logic        row_last;

  int          rows_waiting;
  int          mismatch_count;
  int          burst_left = 0;
  int          idle_cycles = 0;
  int          stall_left = 0;
  stall_mode_t stall_mode = STALL_NONE;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  edge_force_virial_accumulator dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .role(role), .edge_valid(edge_valid),
    .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .spin_x(spin_x), .spin_y(spin_y), .spin_z(spin_z), .node_last(node_last),
    .out_valid(out_valid), .out_stall(out_stall), .node_index(node_index),
    .row_kind(row_kind), .val_x(val_x), .val_y(val_y), .val_z(val_z), .row_last(row_last)
  );

  efva_row_checker row_check (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .role(role), .edge_valid(edge_valid),
    .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
    .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
    .spin_x(spin_x), .spin_y(spin_y), .spin_z(spin_z), .node_last(node_last),
    .out_valid(out_valid), .out_stall(out_stall), .node_index(node_index),
    .row_kind(row_kind), .val_x(val_x), .val_y(val_y), .val_z(val_z), .row_last(row_last),
    .rows_waiting(rows_waiting), .mismatch_count(mismatch_count)
  );

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 96);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= stall_left[2];
    endcase
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic edge_item_t uniform(input logic r, input logic ok, input val_t g,
                                         input val_t v, input val_t s, input logic last);
    edge_item_t e;
    e.role    = r;
    e.counted = ok;
    e.grad    = {3{g}};
    e.vec     = {3{v}};
    e.spin    = {3{s}};
    e.last    = last;
    return e;
  endfunction

  function automatic val_t pick_q16();
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return val_t'($urandom_range(0, 255)) - 128;
      default: return val_t'($urandom);
    endcase
  endfunction

  function automatic edge_item_t random_edge_item(input logic last);
    edge_item_t e;
    e.role    = 1'($urandom_range(0, 1));
    e.counted = ($urandom_range(0, 9) != 0);
    for (int i = 0; i < 3; i++) begin
      e.grad[i] = pick_q16();
      e.vec[i]  = pick_q16();
      e.spin[i] = pick_q16();
    end
    e.last = last;
    return e;
  endfunction

  task automatic send_edge(input edge_item_t e);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    role       <= e.role;
    edge_valid <= e.counted;
    grad_x     <= e.grad[0];
    grad_y     <= e.grad[1];
    grad_z     <= e.grad[2];
    vec_x      <= e.vec[0];
    vec_y      <= e.vec[1];
    vec_z      <= e.vec[2];
    spin_x     <= e.spin[0];
    spin_y     <= e.spin[1];
    spin_z     <= e.spin[2];
    node_last  <= e.last;
    in_valid   <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // The block may still hold items that produce no row, so wait out its pipeline too.
  task automatic drain_and_set_spin(input logic en);
    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_waiting != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= en;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    int node_left;
    node_left  = 0;
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_data   <= 1'b0;
    in_valid   <= 1'b0;
    role       <= ROLE_IN;
    edge_valid <= 1'b0;
    grad_x     <= '0;
    grad_y     <= '0;
    grad_z     <= '0;
    vec_x      <= '0;
    vec_y      <= '0;
    vec_z      <= '0;
    spin_x     <= '0;
    spin_y     <= '0;
    spin_z     <= '0;
    node_last  <= 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    drain_and_set_spin(SPIN_OFF);
    send_edge(uniform(ROLE_IN, 1'b0, 7, 7, 7, 1'b1));
    send_edge(uniform(ROLE_OUT, 1'b0, VAL_MAX, VAL_MAX, VAL_MAX, 1'b0));
    send_edge(uniform(ROLE_IN, 1'b1, VAL_MAX, VAL_MIN, VAL_MAX, 1'b0));
    send_edge(uniform(ROLE_IN, 1'b1, VAL_MIN, 0, 0, 1'b0));
    send_edge(uniform(ROLE_OUT, 1'b1, VAL_MIN, VAL_MIN, VAL_MAX, 1'b0));
    send_edge(uniform(ROLE_OUT, 1'b1, VAL_MAX, VAL_MAX, VAL_MIN, 1'b1));
    for (int k = 1; k <= 3; k++) send_edge(uniform(ROLE_OUT, 1'b1, VAL_MIN, VAL_MIN, 0, k == 3));
    for (int k = 1; k <= 3; k++) send_edge(uniform(ROLE_OUT, 1'b1, VAL_MIN, VAL_MAX, 0, k == 3));
    send_edge(uniform(ROLE_OUT, 1'b1, -1, 1, 0, 1'b0));
    send_edge(uniform(ROLE_OUT, 1'b1, 3, -5, 0, 1'b1));

    drain_and_set_spin(SPIN_ON);
    send_edge(uniform(ROLE_OUT, 1'b1, 5, 6, VAL_MAX, 1'b0));
    send_edge(uniform(ROLE_IN, 1'b1, 1, 1, VAL_MAX, 1'b0));
    send_edge(uniform(ROLE_OUT, 1'b0, 1, 1, VAL_MIN, 1'b1));
    send_edge(uniform(ROLE_OUT, 1'b1, 2, 3, 100, 1'b0));
    drain_and_set_spin(SPIN_OFF);
    send_edge(uniform(ROLE_OUT, 1'b1, 2, 3, 200, 1'b1));
    drain_and_set_spin(SPIN_ON);
    send_edge(uniform(ROLE_OUT, 1'b1, -7, 9, VAL_MIN, 1'b1));

    // Phases end at arbitrary items, so spin changes also land in the middle of a node.
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_and_set_spin(ph[0] ? SPIN_ON : SPIN_OFF);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (node_left == 0) begin
          node_left = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
        end
        node_left--;
        send_edge(random_edge_item(node_left == 0));
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (rows_waiting != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/efva_pkg.sv
rtl/core/efva_front.sv
rtl/core/efva_queue.sv
rtl/core/efva_back.sv
rtl/core/efva_emit.sv
rtl/core/edge_force_virial_accumulator.sv
rtl/core/efva_checker.sv
dv/efva_row_checker.sv
dv/edge_force_virial_accumulator_tb.sv
